[rtl/dgt_pkg.sv]
package dgt_pkg;

    // Field widths of the stream words
    localparam int CLASS_W  = 16;
    localparam int SCORE_W  = 16;
    localparam int EDGE_W   = 18;
    localparam int ANGLE_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int STEP_W   = 15;
    localparam int DB_W     = 17;
    localparam int TCLASS_W = 17;
    localparam int CFG_W    = 17;
    localparam int PROD_W   = GAIN_W + EDGE_W;

    // Q16 unity and the smallest allowed step (0.1 degree in 1/256 degree)
    localparam logic [EDGE_W-1:0] Q_ONE    = 18'd65536;
    localparam logic [STEP_W-1:0] MIN_STEP = 15'd26;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_TARGET_CLASS    = 3'd1,
        REG_DEADBAND        = 3'd2,
        REG_PAN_GAIN        = 3'd3,
        REG_TILT_GAIN       = 3'd4,
        REG_STEP_LIMIT      = 3'd5,
        REG_PAN_MAX         = 3'd6,
        REG_TILT_MAX        = 3'd7
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [SCORE_W-1:0]  RST_SCORE_THRESHOLD = 16'd29491;
    localparam logic [TCLASS_W-1:0] RST_TARGET_CLASS    = 17'h1FFFF;
    localparam logic [DB_W-1:0]     RST_DEADBAND        = 17'd3277;
    localparam logic [GAIN_W-1:0]   RST_PAN_GAIN        = 16'd7168;
    localparam logic [GAIN_W-1:0]   RST_TILT_GAIN       = 16'd5120;
    localparam logic [STEP_W-1:0]   RST_STEP_LIMIT      = 15'd1536;
    localparam logic [ANGLE_W-1:0]  RST_PAN_MAX         = 16'd46080;
    localparam logic [ANGLE_W-1:0]  RST_TILT_MAX        = 16'd28160;

endpackage

[rtl/detection_gimbal_tracker.sv]
// Proportional pan/tilt tracker. Detections of one frame stream in one word
// per cycle on s_axis, the frame's final detection marked by tlast. The block
// keeps the first highest-scoring detection of the target class whose score
// reaches the threshold; on the last word it forms the box-center errors,
// skips the frame when none qualified or both lie inside the deadband, and
// otherwise steps the pan and tilt positions by gain * error (floored Q16,
// clamped to the step limit, never below 26) with saturation to the limits,
// emitting both positions as one word on m_axis. A new word is accepted
// every cycle unless the pipeline holds; the last word passes the input
// register, the clamp/select stage, the 16x18 gain multiply stage and the
// step/saturate stage into the output register. The whole pipeline holds
// only while a result is about to enter an output register still waiting to
// be taken. Configuration must be written while no frame is in flight.
module detection_gimbal_tracker
    import dgt_pkg::*;
#(
    parameter int PAN_MIN       = 0,
    parameter int TILT_FLOOR    = 0,
    parameter int NEUTRAL_ANGLE = 23040
)
(
    input  logic         clk,
    input  logic         rst_n,

    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [16:0]  cfg_wdata,

    // detections: class, score, x_min, y_min, x_max, y_max (lowest first)
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tlast,

    // positions: pan_position, tilt_position (lowest first)
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata
);

    localparam logic [ANGLE_W-1:0] PAN_MIN_W    = ANGLE_W'(PAN_MIN);
    localparam logic [ANGLE_W-1:0] TILT_FLOOR_W = ANGLE_W'(TILT_FLOOR);
    localparam logic [ANGLE_W-1:0] NEUTRAL_W    = ANGLE_W'(NEUTRAL_ANGLE);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SCORE_W-1:0]  score_threshold_reg;
    logic [TCLASS_W-1:0] target_class_reg;
    logic [DB_W-1:0]     deadband_reg;
    logic [GAIN_W-1:0]   pan_gain_reg;
    logic [GAIN_W-1:0]   tilt_gain_reg;
    logic [STEP_W-1:0]   step_limit_reg;
    logic [ANGLE_W-1:0]  pan_max_reg;
    logic [ANGLE_W-1:0]  tilt_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_threshold_reg <= RST_SCORE_THRESHOLD;
            target_class_reg    <= RST_TARGET_CLASS;
            deadband_reg        <= RST_DEADBAND;
            pan_gain_reg        <= RST_PAN_GAIN;
            tilt_gain_reg       <= RST_TILT_GAIN;
            step_limit_reg      <= RST_STEP_LIMIT;
            pan_max_reg         <= RST_PAN_MAX;
            tilt_max_reg        <= RST_TILT_MAX;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SCORE_THRESHOLD: score_threshold_reg <= cfg_wdata[SCORE_W-1:0];
                REG_TARGET_CLASS:    target_class_reg    <= cfg_wdata[TCLASS_W-1:0];
                REG_DEADBAND:        deadband_reg        <= cfg_wdata[DB_W-1:0];
                REG_PAN_GAIN:        pan_gain_reg        <= cfg_wdata[GAIN_W-1:0];
                REG_TILT_GAIN:       tilt_gain_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_STEP_LIMIT:      step_limit_reg      <= cfg_wdata[STEP_W-1:0];
                REG_PAN_MAX:         pan_max_reg         <= cfg_wdata[ANGLE_W-1:0];
                REG_TILT_MAX:        tilt_max_reg        <= cfg_wdata[ANGLE_W-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: hold everything only when a result would land in
    // an output register that is still occupied.
    // ------------------------------------------------------------------
    logic c_valid_reg;
    logic out_valid_reg;
    logic stall;
    logic accept;

    assign stall         = c_valid_reg && out_valid_reg && !m_axis_tready;
    assign s_axis_tready = !stall;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic                a_valid_reg;
    logic                a_last_reg;
    logic [CLASS_W-1:0]  a_class_reg;
    logic [SCORE_W-1:0]  a_score_reg;
    logic [EDGE_W-1:0]   a_x1_reg;
    logic [EDGE_W-1:0]   a_y1_reg;
    logic [EDGE_W-1:0]   a_x2_reg;
    logic [EDGE_W-1:0]   a_y2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_class_reg <= s_axis_tdata[15:0];
            a_score_reg <= s_axis_tdata[31:16];
            a_x1_reg    <= s_axis_tdata[49:32];
            a_y1_reg    <= s_axis_tdata[67:50];
            a_x2_reg    <= s_axis_tdata[85:68];
            a_y2_reg    <= s_axis_tdata[103:86];
            a_last_reg  <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: clamp edges, select the best detection, form errors on last
    // ------------------------------------------------------------------
    function automatic logic [EDGE_W-2:0] clamp_edge(input logic [EDGE_W-1:0] v);
        if (v[EDGE_W-1])
            clamp_edge = '0;
        else if (v > Q_ONE)
            clamp_edge = Q_ONE[EDGE_W-2:0];
        else
            clamp_edge = v[EDGE_W-2:0];
    endfunction

    logic                best_found_reg;
    logic [SCORE_W-1:0]  best_score_reg;
    logic [EDGE_W-1:0]   best_x_sum_reg;
    logic [EDGE_W-1:0]   best_y_sum_reg;

    logic [EDGE_W-1:0]   x_sum;
    logic [EDGE_W-1:0]   y_sum;
    logic                class_ok;
    logic                match;
    logic                take;
    logic                found_next;
    logic [EDGE_W-1:0]   x_sel;
    logic [EDGE_W-1:0]   y_sel;

    always_comb
    begin
        x_sum    = {1'b0, clamp_edge(a_x1_reg)} + {1'b0, clamp_edge(a_x2_reg)};
        y_sum    = {1'b0, clamp_edge(a_y1_reg)} + {1'b0, clamp_edge(a_y2_reg)};
        // a negative target class accepts any class
        class_ok = target_class_reg[TCLASS_W-1] ||
                   (target_class_reg[CLASS_W-1:0] == a_class_reg);
        match    = (a_score_reg >= score_threshold_reg) && class_ok;
        // replace only on a strictly greater score: ties keep the earlier box
        take     = a_valid_reg && match &&
                   (!best_found_reg || (a_score_reg > best_score_reg));
        found_next = best_found_reg || take;
        x_sel    = take ? x_sum : best_x_sum_reg;
        y_sel    = take ? y_sum : best_y_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            best_score_reg <= '0;
            best_x_sum_reg <= '0;
            best_y_sum_reg <= '0;
        end
        else if (!stall && a_valid_reg)
        begin
            if (a_last_reg)
            begin
                // frame done: drop the selection
                best_found_reg <= 1'b0;
                best_score_reg <= '0;
                best_x_sum_reg <= '0;
                best_y_sum_reg <= '0;
            end
            else if (take)
            begin
                best_found_reg <= 1'b1;
                best_score_reg <= a_score_reg;
                best_x_sum_reg <= x_sum;
                best_y_sum_reg <= y_sum;
            end
        end
    end

    logic                       b_valid_reg;
    logic signed [EDGE_W-1:0]   b_ex_reg;
    logic signed [EDGE_W-1:0]   b_ey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            b_valid_reg <= a_valid_reg && a_last_reg && found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            // center error in Q16: sum of both edges minus one
            b_ex_reg <= $signed(x_sel - Q_ONE);
            b_ey_reg <= $signed(y_sel - Q_ONE);
        end
    end

    // ------------------------------------------------------------------
    // Stage C: deadband test and gain multiply
    // ------------------------------------------------------------------
    logic [DB_W-1:0]            abs_ex;
    logic [DB_W-1:0]            abs_ey;
    logic                       in_band;
    logic signed [PROD_W-1:0]   pan_prod;
    logic signed [PROD_W-1:0]   tilt_prod;

    always_comb
    begin
        abs_ex    = b_ex_reg[EDGE_W-1] ? DB_W'(-b_ex_reg) : b_ex_reg[DB_W-1:0];
        abs_ey    = b_ey_reg[EDGE_W-1] ? DB_W'(-b_ey_reg) : b_ey_reg[DB_W-1:0];
        in_band   = (abs_ex < deadband_reg) && (abs_ey < deadband_reg);
        pan_prod  = $signed(pan_gain_reg) * b_ex_reg;
        tilt_prod = $signed(tilt_gain_reg) * b_ey_reg;
    end

    logic signed [PROD_W-1:0]   c_pan_prod_reg;
    logic signed [PROD_W-1:0]   c_tilt_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            c_valid_reg <= b_valid_reg && !in_band;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            c_pan_prod_reg  <= pan_prod;
            c_tilt_prod_reg <= tilt_prod;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: floor off the Q16 fraction, clamp the step, move and saturate
    // ------------------------------------------------------------------
    function automatic logic signed [ANGLE_W-1:0] make_step(
        input logic signed [PROD_W-1:0] prod,
        input logic [STEP_W-1:0]        lim
    );
        logic signed [EDGE_W-1:0] s;
        logic signed [EDGE_W-1:0] lim_s;
        // arithmetic drop of the Q16 fraction floors toward minus infinity
        s     = prod[PROD_W-1:16];
        lim_s = $signed({{(EDGE_W-STEP_W){1'b0}}, lim});
        if (s > lim_s)
            s = lim_s;
        else if (s < -lim_s)
            s = -lim_s;
        make_step = s[ANGLE_W-1:0];
    endfunction

    function automatic logic [ANGLE_W-1:0] move_pos(
        input logic [ANGLE_W-1:0]        pos,
        input logic signed [ANGLE_W-1:0] step,
        input logic [ANGLE_W-1:0]        lo,
        input logic [ANGLE_W-1:0]        hi
    );
        logic signed [ANGLE_W+1:0] v;
        v = $signed({2'b00, pos}) + $signed({{2{step[ANGLE_W-1]}}, step});
        // upper limit first, so a crossed pair of limits lands on the lower one
        if (v > $signed({2'b00, hi}))
            v = $signed({2'b00, hi});
        if (v < $signed({2'b00, lo}))
            v = $signed({2'b00, lo});
        move_pos = v[ANGLE_W-1:0];
    endfunction

    logic [STEP_W-1:0]   lim;
    logic [ANGLE_W-1:0]  pan_position_next;
    logic [ANGLE_W-1:0]  tilt_position_next;
    logic [ANGLE_W-1:0]  pan_position_reg;
    logic [ANGLE_W-1:0]  tilt_position_reg;

    always_comb
    begin
        lim = (step_limit_reg < MIN_STEP) ? MIN_STEP : step_limit_reg;
        pan_position_next  = move_pos(pan_position_reg,
                                      make_step(c_pan_prod_reg, lim),
                                      PAN_MIN_W, pan_max_reg);
        tilt_position_next = move_pos(tilt_position_reg,
                                      make_step(c_tilt_prod_reg, lim),
                                      TILT_FLOOR_W, tilt_max_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_position_reg  <= NEUTRAL_W;
            tilt_position_reg <= NEUTRAL_W;
        end
        else if (!stall && c_valid_reg)
        begin
            pan_position_reg  <= pan_position_next;
            tilt_position_reg <= tilt_position_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [31:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!stall && c_valid_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall && c_valid_reg)
        begin
            out_data_reg <= {tilt_position_next, pan_position_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
